@@ rtl/cmpr_pkg.sv @@
// shared types, constants and helpers for the contact manifold point reduction
`timescale 1ns / 1ps

package cmpr_pkg;

    localparam int MAX_CONTACTS = 4;
    localparam int SLOT_W       = 2;
    localparam int CNT_W        = 3;
    localparam int COORD_W      = 16;
    localparam int POINT_W      = 3 * COORD_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int MUL_W        = DIFF_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int HALF_W       = DIFF_W;
    localparam int MAG_W        = 2 * HALF_W;
    localparam int SCORE_W      = 70;
    localparam int STEP_W       = 3;
    localparam int IN_DATA_W    = 4 * COORD_W;
    localparam int OUT_DATA_W   = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SLOT,
        ST_READ,
        ST_COMP,
        ST_CROSS,
        ST_SLOT_END,
        ST_WRITE,
        ST_RESULT
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_APPEND,
        OP_REPLACE,
        OP_SLOT_CLR,
        OP_CROSS_END,
        OP_SLOT_END,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_B,
        LD_C,
        LD_D
    } ld_sel_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_P1,
        MUL_P2,
        MUL_LL,
        MUL_HL,
        MUL_HH
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_CLR,
        ACC_LL,
        ACC_HL,
        ACC_HH
    } acc_sel_t;

    typedef struct packed {
        dp_op_t            op;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] rd_addr;
        ld_sel_t           ld;
        logic              uv_load;
        mul_sel_t          mul;
        logic [1:0]        comp;
        logic              t_load;
        logic              mag_load;
        acc_sel_t          acc;
    } dp_cmd_t;

    typedef struct packed {
        logic              is_clear;
        logic              full;
        logic              prot_valid;
        logic [SLOT_W-1:0] prot_idx;
        logic              out_free;
    } dp_status_t;

    // n-th slot other than i, in ascending order
    function automatic logic [SLOT_W-1:0] other_slot(input logic [SLOT_W-1:0] i,
                                                     input logic [SLOT_W-1:0] n);
        logic [SLOT_W-1:0] r;
        r = (n >= i) ? n + 2'd1 : n;
        return r;
    endfunction

endpackage

@@ rtl/cmpr_ctrl.sv @@
// controller state machine sequencing input, the replacement score search and the result
`timescale 1ns / 1ps

module cmpr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  cmpr_pkg::dp_status_t status,
    output cmpr_pkg::dp_cmd_t    cmd
);
    import cmpr_pkg::*;

    ctl_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]        pair_reg, pair_next;
    logic [1:0]        comp_reg, comp_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [SLOT_W-1:0] o0, o1, o2, b_addr, c_addr, d_addr;

    assign o0 = other_slot(slot_reg, 2'd0);
    assign o1 = other_slot(slot_reg, 2'd1);
    assign o2 = other_slot(slot_reg, 2'd2);

    // pairings: (b | c,d) = (o0 | o1,o2), (o1 | o0,o2), (o2 | o0,o1)
    always_comb
    begin
        b_addr = o0;
        c_addr = o1;
        d_addr = o2;
        case (pair_reg)
            2'd1:
            begin
                b_addr = o1;
                c_addr = o0;
            end
            2'd2:
            begin
                b_addr = o2;
                c_addr = o0;
                d_addr = o1;
            end
            default:
            begin
                b_addr = o0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            pair_reg  <= '0;
            comp_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            pair_reg  <= pair_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        pair_next  = pair_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                slot_next = '0;
                if (status.is_clear || !status.full)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                pair_next = '0;
                step_next = '0;
                if (status.prot_valid && status.prot_idx == slot_reg)
                begin
                    state_next = ST_SLOT_END;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (step_reg == STEP_W'(4))
                begin
                    step_next  = '0;
                    comp_next  = '0;
                    state_next = ST_COMP;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_COMP:
            begin
                if (step_reg == STEP_W'(6))
                begin
                    step_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = ST_CROSS;
                    end
                    else
                    begin
                        comp_next = comp_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_CROSS:
            begin
                step_next = '0;
                if (pair_reg == 2'd2)
                begin
                    state_next = ST_SLOT_END;
                end
                else
                begin
                    pair_next  = pair_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_SLOT_END:
            begin
                if (slot_reg == SLOT_W'(MAX_CONTACTS - 1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SLOT;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.ld        = LD_NONE;
        cmd.mul       = MUL_NONE;
        cmd.acc       = ACC_NONE;
        cmd.slot      = slot_reg;
        cmd.comp      = comp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_DECIDE:
            begin
                if (status.is_clear)
                begin
                    cmd.op = OP_CLEAR;
                end
                else if (!status.full)
                begin
                    cmd.op = OP_APPEND;
                end
            end
            ST_SLOT:
            begin
                cmd.op = OP_SLOT_CLR;
            end
            ST_READ:
            begin
                // registered read: address now, data lands in rd_reg in the next cycle
                case (step_reg)
                    3'd0:    cmd.rd_addr = b_addr;
                    3'd1:
                    begin
                        cmd.rd_addr = c_addr;
                        cmd.ld      = LD_B;
                    end
                    3'd2:
                    begin
                        cmd.rd_addr = d_addr;
                        cmd.ld      = LD_C;
                    end
                    3'd3:    cmd.ld = LD_D;
                    default:
                    begin
                        cmd.uv_load = 1'b1;
                        cmd.acc     = ACC_CLR;
                    end
                endcase
            end
            ST_COMP:
            begin
                case (step_reg)
                    3'd0:    cmd.mul = MUL_P1;
                    3'd1:
                    begin
                        cmd.mul    = MUL_P2;
                        cmd.t_load = 1'b1;
                    end
                    3'd2:    cmd.mag_load = 1'b1;
                    3'd3:    cmd.mul = MUL_LL;
                    3'd4:
                    begin
                        cmd.mul = MUL_HL;
                        cmd.acc = ACC_LL;
                    end
                    3'd5:
                    begin
                        cmd.mul = MUL_HH;
                        cmd.acc = ACC_HL;
                    end
                    default: cmd.acc = ACC_HH;
                endcase
            end
            ST_CROSS:    cmd.op = OP_CROSS_END;
            ST_SLOT_END: cmd.op = OP_SLOT_END;
            ST_WRITE:    cmd.op = OP_REPLACE;
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_RESULT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

@@ rtl/cmpr_datapath.sv @@
// contact store, shared multiplier, score accumulation and result register
`timescale 1ns / 1ps

module cmpr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cmpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  cmpr_pkg::dp_cmd_t               cmd,
    output cmpr_pkg::dp_status_t            status,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cmpr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cmpr_pkg::*;

    logic [POINT_W-1:0]        coord_mem [MAX_CONTACTS];
    logic signed [COORD_W-1:0] depth_reg [MAX_CONTACTS];
    logic [CNT_W-1:0]          count_reg;

    logic [POINT_W-1:0]        np_reg;
    logic signed [COORD_W-1:0] nd_reg;
    logic                      opc_reg;

    logic [POINT_W-1:0]        rd_reg, pb_reg, pc_reg, pd_reg;
    logic signed [DIFF_W-1:0]  u_reg [3];
    logic signed [DIFF_W-1:0]  v_reg [3];
    logic signed [PROD_W-1:0]  prod_reg, t_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [SCORE_W-1:0]        acc_reg, score_reg, best_reg;
    logic [SLOT_W-1:0]         pick_reg, slot_w_reg;
    logic                      repl_reg;
    logic                      m_valid_reg;
    logic [OUT_DATA_W-1:0]     out_reg;

    logic signed [MUL_W-1:0]   ma, mb;
    logic signed [DIFF_W-1:0]  ua, ub, va, vb;
    logic signed [PROD_W:0]    pdiff, pabs;
    logic [SCORE_W-1:0]        prod_ext;
    logic                      wr_en;
    logic [SLOT_W-1:0]         wr_addr;

    logic signed [COORD_W-1:0] prot_d;
    logic                      prot_valid;
    logic [SLOT_W-1:0]         prot_idx;
    logic signed [COORD_W-1:0] deep_d;
    logic [SLOT_W-1:0]         deep_s;

    function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [POINT_W-1:0] a,
                                                            input logic [POINT_W-1:0] b,
                                                            input int k);
        logic signed [DIFF_W-1:0] ax, bx;
        ax = DIFF_W'($signed(a[COORD_W*k +: COORD_W]));
        bx = DIFF_W'($signed(b[COORD_W*k +: COORD_W]));
        return ax - bx;
    endfunction

    // a stored point deeper than the new one is protected; the deepest wins, the lowest slot on ties
    always_comb
    begin
        prot_d     = nd_reg;
        prot_valid = 1'b0;
        prot_idx   = '0;
        for (int i = 0; i < MAX_CONTACTS; i++)
        begin
            if (depth_reg[i] > prot_d)
            begin
                prot_d     = depth_reg[i];
                prot_valid = 1'b1;
                prot_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        deep_d = '0;
        deep_s = '0;
        for (int i = 0; i < MAX_CONTACTS; i++)
        begin
            if (CNT_W'(i) < count_reg && (i == 0 || depth_reg[i] > deep_d))
            begin
                deep_d = depth_reg[i];
                deep_s = SLOT_W'(i);
            end
        end
    end

    assign status.is_clear   = opc_reg;
    assign status.full       = (count_reg == CNT_W'(MAX_CONTACTS));
    assign status.prot_valid = prot_valid;
    assign status.prot_idx   = prot_idx;
    assign status.out_free   = !m_valid_reg || m_axis_tready;

    // component operand pairs: x = u1v2-u2v1, y = u2v0-u0v2, z = u0v1-u1v0
    always_comb
    begin
        case (cmd.comp)
            2'd0:
            begin
                ua = u_reg[1]; ub = u_reg[2]; va = v_reg[1]; vb = v_reg[2];
            end
            2'd1:
            begin
                ua = u_reg[2]; ub = u_reg[0]; va = v_reg[2]; vb = v_reg[0];
            end
            default:
            begin
                ua = u_reg[0]; ub = u_reg[1]; va = v_reg[0]; vb = v_reg[1];
            end
        endcase
    end

    always_comb
    begin
        case (cmd.mul)
            MUL_P1:
            begin
                ma = MUL_W'(ua);
                mb = MUL_W'(vb);
            end
            MUL_P2:
            begin
                ma = MUL_W'(ub);
                mb = MUL_W'(va);
            end
            MUL_LL:
            begin
                ma = {1'b0, mag_reg[HALF_W-1:0]};
                mb = {1'b0, mag_reg[HALF_W-1:0]};
            end
            MUL_HL:
            begin
                ma = {1'b0, mag_reg[MAG_W-1:HALF_W]};
                mb = {1'b0, mag_reg[HALF_W-1:0]};
            end
            MUL_HH:
            begin
                ma = {1'b0, mag_reg[MAG_W-1:HALF_W]};
                mb = {1'b0, mag_reg[MAG_W-1:HALF_W]};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign pdiff    = (PROD_W + 1)'(t_reg) - (PROD_W + 1)'(prod_reg);
    assign pabs     = pdiff[PROD_W] ? -pdiff : pdiff;
    assign prod_ext = SCORE_W'(unsigned'(prod_reg));

    assign wr_en   = (cmd.op == OP_APPEND) || (cmd.op == OP_REPLACE);
    assign wr_addr = (cmd.op == OP_APPEND) ? count_reg[SLOT_W-1:0] : pick_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem[wr_addr] <= np_reg;
            depth_reg[wr_addr] <= nd_reg;
        end
        rd_reg <= coord_mem[cmd.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            np_reg  <= s_axis_tdata[POINT_W-1:0];
            nd_reg  <= s_axis_tdata[IN_DATA_W-1:POINT_W];
            opc_reg <= s_axis_tuser;
        end
        case (cmd.ld)
            LD_B:    pb_reg <= rd_reg;
            LD_C:    pc_reg <= rd_reg;
            LD_D:    pd_reg <= rd_reg;
            default: ;
        endcase
        if (cmd.uv_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k] <= coord_diff(np_reg, pb_reg, k);
                v_reg[k] <= coord_diff(pc_reg, pd_reg, k);
            end
        end
        prod_reg <= ma * mb;
        if (cmd.t_load)
        begin
            t_reg <= prod_reg;
        end
        if (cmd.mag_load)
        begin
            mag_reg <= pabs[MAG_W-1:0];
        end
        // square of the component split into 17-bit halves
        case (cmd.acc)
            ACC_CLR: acc_reg <= '0;
            ACC_LL:  acc_reg <= acc_reg + prod_ext;
            ACC_HL:  acc_reg <= acc_reg + (prod_ext << (HALF_W + 1));
            ACC_HH:  acc_reg <= acc_reg + (prod_ext << (2 * HALF_W));
            default: ;
        endcase
        case (cmd.op)
            OP_SLOT_CLR: score_reg <= '0;
            OP_CROSS_END:
            begin
                if (acc_reg > score_reg)
                begin
                    score_reg <= acc_reg;
                end
            end
            OP_SLOT_END:
            begin
                if (cmd.slot == '0 || score_reg > best_reg)
                begin
                    best_reg <= score_reg;
                    pick_reg <= cmd.slot;
                end
            end
            OP_CLEAR:
            begin
                slot_w_reg <= '0;
                repl_reg   <= 1'b0;
            end
            OP_APPEND:
            begin
                slot_w_reg <= count_reg[SLOT_W-1:0];
                repl_reg   <= 1'b0;
            end
            OP_REPLACE:
            begin
                slot_w_reg <= pick_reg;
                repl_reg   <= 1'b1;
            end
            OP_RESULT:
            begin
                out_reg <= {deep_d, deep_s, count_reg, repl_reg, slot_w_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (cmd.op == OP_APPEND)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.op == OP_RESULT)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

@@ rtl/contact_manifold_point_reduction_top.sv @@
// top level of the four-point contact manifold reduction
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: x, y, z, penetration; tuser: opcode
//  m_axis    out  m_axis_tvalid/tready      tdata: slot, replaced, count, deepest slot, depth
//
// clear and append pass from the decide state straight to the result; an add to a full store
// runs a score search on the single shared 18x18 multiplier (15 products for each of up to
// twelve cross products, the protected slot skipped).
// one item is worked on at a time; the next one is taken while a result waits.
// reset empties the store; a stalled result holds in the output register.
`timescale 1ns / 1ps

module contact_manifold_point_reduction_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x[15:0], y[31:16], z[47:32], penetration[63:48]
    input  logic [cmpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot_written[1:0], was_replaced[2], contact_count[5:3], deepest_slot[7:6],
    // deepest_depth[23:8]
    output logic [cmpr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cmpr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cmpr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cmpr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/cmpr_checker.sv @@
// port-level checks on the reduction block, bound to the top level
`timescale 1ns / 1ps

module cmpr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cmpr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cmpr_pkg::*;

    // one item at a time: an accepted transaction closes the input
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a stalled result transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:3] <= 3'(MAX_CONTACTS))
        else $error("contact count out of range");

    // replacement only happens on a full store
    a_repl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[5:3] == 3'(MAX_CONTACTS))
        else $error("replacement without full store");

    // empty store reports no deepest contact
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:3] == 3'd0 |-> m_axis_tdata[23:6] == '0)
        else $error("deepest contact reported on empty store");

endmodule

bind contact_manifold_point_reduction_top cmpr_checker u_cmpr_checker (.*);
